// ===== rtl/core/scg_pkg.sv =====
// ----------------------------------------------------------------------------
// scg_pkg
// Shared widths, register codes, reset values and mask and bit-count helpers for the
// subpixel coverage glyph renderer.
// ----------------------------------------------------------------------------
package scg_pkg;

  localparam int unsigned TexelW   = 16;
  localparam int unsigned GrayW    = 8;
  localparam int unsigned IndexW   = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned DimW     = 9;
  localparam int unsigned ShiftW   = 2;
  localparam int unsigned OffsW    = 12;
  localparam int unsigned StrideW  = 13;
  localparam int unsigned CountW   = 5;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;

  localparam logic [DimW-1:0]    GlyphWidthReset  = 9'd16;
  localparam logic [DimW-1:0]    GlyphHeightReset = 9'd16;
  localparam logic [StrideW-1:0] DestStrideReset  = 13'd256;

  localparam logic [GrayW-1:0]  GrayFull  = 8'd255;
  localparam logic [CountW-1:0] CountFull = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGlyphWidth  = 3'd0,
    CfgGlyphHeight = 3'd1,
    CfgShiftX      = 3'd2,
    CfgShiftY      = 3'd3,
    CfgDestLeft    = 3'd4,
    CfgDestTop     = 3'd5,
    CfgDestStride  = 3'd6
  } cfg_reg_e;

  function automatic logic [TexelW-1:0] keep_cols(input logic [ShiftW-1:0] shift);
    logic [TexelW-1:0] m;
    case (shift)
      2'd0:    m = 16'hffff;
      2'd1:    m = 16'h7777;
      2'd2:    m = 16'h3333;
      default: m = 16'h1111;
    endcase
    return m;
  endfunction

  function automatic logic [TexelW-1:0] keep_rows(input logic [ShiftW-1:0] shift);
    logic [TexelW-1:0] m;
    case (shift)
      2'd0:    m = 16'hffff;
      2'd1:    m = 16'h0fff;
      2'd2:    m = 16'h00ff;
      default: m = 16'h000f;
    endcase
    return m;
  endfunction

  function automatic logic [CountW-1:0] popcount16(input logic [TexelW-1:0] v);
    logic [2:0]        nib [4];
    logic [CountW-1:0] sum;
    for (int n = 0; n < 4; n++) begin
      nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
    end
    sum = CountW'(nib[0]) + CountW'(nib[1]) + CountW'(nib[2]) + CountW'(nib[3]);
    return sum;
  endfunction

endpackage

// ===== rtl/core/scg_line_buf.sv =====
// ----------------------------------------------------------------------------
// scg_line_buf
// Line buffer holding the previous texel row, registered read
// with write-to-read forwarding for the same entry.
// ----------------------------------------------------------------------------
module scg_line_buf #(
  parameter int unsigned Depth = scg_pkg::DefMaxWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [$clog2(Depth)-1:0]    waddr_i,
  input  logic [scg_pkg::TexelW-1:0]  wdata_i,
  input  logic [$clog2(Depth)-1:0]    raddr_i,
  output logic [scg_pkg::TexelW-1:0]  rdata_o
);
  import scg_pkg::*;

  logic [TexelW-1:0] mem [Depth];
  logic [TexelW-1:0] rdata_q;
  logic [TexelW-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// ===== rtl/core/subpixel_coverage_glyph_render.sv =====
// pipeline: an accepted texel's result is registered in stage 1, then stage 2
// throughput: one texel per cycle while out_ready_i does not stall the output
// the line buffer read for the next column is issued ahead, from col_d
// reset: counters, neighbor texels, pipeline valids and registers to defaults
// reset: the line buffer is not cleared, rows are written before being read
// ----------------------------------------------------------------------------
// subpixel_coverage_glyph_render
// Glyph texel stream to gray level and destination index, using the left,
// upper and upper-left neighbors masked by a quarter-pixel shift.
// ----------------------------------------------------------------------------
module subpixel_coverage_glyph_render #(
  parameter int unsigned MaxWidth  = scg_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = scg_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [scg_pkg::TexelW-1:0]    texel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [scg_pkg::GrayW-1:0]     gray_o,
  output logic [scg_pkg::IndexW-1:0]    dest_index_o,
  output logic                          last_pixel_o
);
  import scg_pkg::*;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned MaxWH = (MaxWidth > MaxHeight) ? MaxWidth : MaxHeight;
  localparam int unsigned LimW  = ($clog2(MaxWH + 1) > DimW) ? $clog2(MaxWH + 1) : DimW;
  localparam int unsigned SumW  = OffsW + 1;
  localparam int unsigned ProdW = SumW + StrideW;
  localparam logic [LimW-1:0] WidthMax  = LimW'(MaxWidth);
  localparam logic [LimW-1:0] HeightMax = LimW'(MaxHeight);

  logic [DimW-1:0]    glyph_width_q, glyph_height_q;
  logic [ShiftW-1:0]  shift_x_q, shift_y_q;
  logic [OffsW-1:0]   dest_left_q, dest_top_q;
  logic [StrideW-1:0] dest_stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q  <= GlyphWidthReset;
      glyph_height_q <= GlyphHeightReset;
      shift_x_q      <= '0;
      shift_y_q      <= '0;
      dest_left_q    <= '0;
      dest_top_q     <= '0;
      dest_stride_q  <= DestStrideReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGlyphWidth:  glyph_width_q  <= cfg_wdata_i[DimW-1:0];
        CfgGlyphHeight: glyph_height_q <= cfg_wdata_i[DimW-1:0];
        CfgShiftX:      shift_x_q      <= cfg_wdata_i[ShiftW-1:0];
        CfgShiftY:      shift_y_q      <= cfg_wdata_i[ShiftW-1:0];
        CfgDestLeft:    dest_left_q    <= cfg_wdata_i[OffsW-1:0];
        CfgDestTop:     dest_top_q     <= cfg_wdata_i[OffsW-1:0];
        CfgDestStride:  dest_stride_q  <= cfg_wdata_i[StrideW-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline valids
  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready, accept;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && s1_ready;

  // position counters
  logic [LimW-1:0] width_ext, height_ext, w_eff, h_eff;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            row_end, glyph_end;

  assign width_ext  = LimW'(glyph_width_q);
  assign height_ext = LimW'(glyph_height_q);
  assign w_eff = (width_ext == '0) ? LimW'(1) :
                 (width_ext > WidthMax) ? WidthMax : width_ext;
  assign h_eff = (height_ext == '0) ? LimW'(1) :
                 (height_ext > HeightMax) ? HeightMax : height_ext;

  assign row_end   = (LimW'(col_q) + LimW'(1)) >= w_eff;
  assign glyph_end = row_end && ((LimW'(row_q) + LimW'(1)) >= h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = glyph_end ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // neighbor texels
  logic [TexelW-1:0] above_raw, left_q, upper_left_q;

  scg_line_buf #(
    .Depth (MaxWidth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (texel_i),
    .raddr_i (col_d),
    .rdata_o (above_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      left_q       <= '0;
      upper_left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        left_q       <= texel_i;
        upper_left_q <= above_raw;
      end
    end
  end

  // coverage count
  logic [TexelW-1:0] left_nb, above_nb, above_left_nb, kc, kr, merged;
  logic [CountW-1:0] count;

  assign left_nb       = (col_q != '0) ? left_q : '0;
  assign above_nb      = (row_q != '0) ? above_raw : '0;
  assign above_left_nb = ((col_q != '0) && (row_q != '0)) ? upper_left_q : '0;
  assign kc = keep_cols(shift_x_q);
  assign kr = keep_rows(shift_y_q);
  assign merged = (texel_i & kc & kr) | (left_nb & ~kc & kr) |
                  (above_nb & kc & ~kr) | (above_left_nb & ~kc & ~kr);
  assign count  = popcount16(merged);

  // destination index, first half
  logic [SumW-1:0]  row_abs, col_abs;
  logic [ProdW-1:0] prod_full;

  assign row_abs   = SumW'(dest_top_q) + SumW'(row_q);
  assign col_abs   = SumW'(dest_left_q) + SumW'(col_q);
  assign prod_full = ProdW'(row_abs) * ProdW'(dest_stride_q);

  // stage 1
  logic [CountW-1:0] s1_count_q;
  logic [IndexW-1:0] s1_prod_q;
  logic [SumW-1:0]   s1_offs_q;
  logic              s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_count_q <= count;
      s1_prod_q  <= prod_full[IndexW-1:0];
      s1_offs_q  <= col_abs;
      s1_last_q  <= glyph_end;
    end
  end

  // stage 2, output word
  logic [GrayW-1:0]  gray_q;
  logic [IndexW-1:0] index_q;
  logic              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      gray_q  <= (s1_count_q == CountFull) ? GrayFull : GrayW'({s1_count_q[3:0], 4'h0});
      index_q <= s1_prod_q + IndexW'(s1_offs_q);
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign gray_o       = gray_q;
  assign dest_index_o = index_q;
  assign last_pixel_o = last_q;

endmodule

// ===== verif/tb_subpixel_coverage_glyph_render.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subpixel_coverage_glyph_render
// Streams coverage texels through the glyph renderer under random idling on
// both sides and checks every output word's gray level, destination index
// and last-pixel mark against a checked table row's value, else against a
// cycle-free predictor. A directed table covers reset values, edges, wraps,
// clamping and extremes; random glyph shapes, shifts and placements follow.
// ----------------------------------------------------------------------------
module tb_subpixel_coverage_glyph_render;
  import scg_pkg::*;

  localparam int unsigned MaxW       = DefMaxWidth;
  localparam int unsigned MaxH       = DefMaxHeight;
  localparam int unsigned ColBits    = $clog2(MaxW);
  localparam int unsigned TotalItems = 1150;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned SettleWait = 4;

  typedef enum bit {StepTexel, StepWrite} step_kind_e;

  typedef struct packed {
    logic [GrayW-1:0]  gray;
    logic [IndexW-1:0] index;
    logic              last;
  } pixel_t;

  typedef struct packed {
    step_kind_e  kind;
    cfg_reg_e    sel;
    logic [15:0] value;
    bit          checked;
    pixel_t      want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [TexelW-1:0]   texel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [GrayW-1:0]    gray_o;
  logic [IndexW-1:0]   dest_index_o;
  logic                last_pixel_o;

  // predictor state and register shadow
  logic [TexelW-1:0]  line_buf [MaxW];
  logic [TexelW-1:0]  left_texel;
  logic [TexelW-1:0]  corner_texel;
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [DimW-1:0]    glyph_w;
  logic [DimW-1:0]    glyph_h;
  logic [ShiftW-1:0]  shift_x;
  logic [ShiftW-1:0]  shift_y;
  logic [OffsW-1:0]   dest_left;
  logic [OffsW-1:0]   dest_top;
  logic [StrideW-1:0] dest_stride;

  pixel_t      pixel_q [$];
  int unsigned texels_sent;
  int unsigned mismatch_count;
  int unsigned feed_pace;
  int unsigned sink_pace;
  bit          hold_req;

  plan_row_t plan [36] = '{
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b1, '{8'd255, 24'd0, 1'b0}},
    '{StepTexel, CfgGlyphWidth,  16'h0000, 1'b1, '{8'd0, 24'd1, 1'b0}},
    '{StepTexel, CfgGlyphWidth,  16'h8000, 1'b1, '{8'd16, 24'd2, 1'b0}},
    '{StepWrite, CfgGlyphWidth,  16'd2,    1'b0, '0},
    '{StepWrite, CfgGlyphHeight, 16'd2,    1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'h0001, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'h1248, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hfffe, 1'b0, '0},
    '{StepWrite, CfgShiftX,      16'd3,    1'b0, '0},
    '{StepWrite, CfgShiftY,      16'd3,    1'b0, '0},
    '{StepWrite, CfgDestLeft,    16'h0fff, 1'b0, '0},
    '{StepWrite, CfgDestTop,     16'h0fff, 1'b0, '0},
    '{StepWrite, CfgDestStride,  16'h1fff, 1'b0, '0},
    '{StepWrite, CfgGlyphWidth,  16'd0,    1'b0, '0},
    '{StepWrite, CfgGlyphHeight, 16'd0,    1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b1, '{8'd16, 24'hffe000, 1'b1}},
    '{StepWrite, CfgDestStride,  16'd0,    1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'h0000, 1'b1, '{8'd0, 24'd4095, 1'b1}},
    '{StepWrite, CfgShiftX,      16'd2,    1'b0, '0},
    '{StepWrite, CfgShiftY,      16'd2,    1'b0, '0},
    '{StepWrite, CfgDestLeft,    16'd0,    1'b0, '0},
    '{StepWrite, CfgDestTop,     16'd0,    1'b0, '0},
    '{StepWrite, CfgDestStride,  16'd1,    1'b0, '0},
    '{StepWrite, CfgGlyphWidth,  16'd2,    1'b0, '0},
    '{StepWrite, CfgGlyphHeight, 16'd2,    1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hffff, 1'b1, '{8'd255, 24'd2, 1'b1}},
    '{StepWrite, CfgShiftX,      16'd1,    1'b0, '0},
    '{StepWrite, CfgShiftY,      16'd0,    1'b0, '0},
    '{StepWrite, CfgGlyphWidth,  16'd3,    1'b0, '0},
    '{StepWrite, CfgGlyphHeight, 16'd1,    1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'h8888, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'h7777, 1'b0, '0},
    '{StepTexel, CfgGlyphWidth,  16'hf0f0, 1'b0, '0}
  };

  subpixel_coverage_glyph_render i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .texel_i      (texel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .gray_o       (gray_o),
    .dest_index_o (dest_index_o),
    .last_pixel_o (last_pixel_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned active_dim(input logic [DimW-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (32'(v) > limit) return limit;
    return 32'(v);
  endfunction

  function automatic int unsigned draw_wait(input int unsigned pace);
    case (pace)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [TexelW-1:0] draw_mask();
    case ($urandom_range(0, 7))
      0:       return 16'hffff;
      1:       return 16'h0000;
      2:       return 16'hffff ^ (16'h1 << $urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd4095;
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic void clear_model();
    foreach (line_buf[i]) line_buf[i] = '0;
    left_texel   = '0;
    corner_texel = '0;
    col_cnt      = 0;
    row_cnt      = 0;
    glyph_w      = GlyphWidthReset;
    glyph_h      = GlyphHeightReset;
    shift_x      = '0;
    shift_y      = '0;
    dest_left    = '0;
    dest_top     = '0;
    dest_stride  = DestStrideReset;
  endfunction

  // one texel in, one pixel out; advances neighbor and position state
  function automatic pixel_t render_texel(input logic [TexelW-1:0] cur);
    int unsigned       w;
    int unsigned       h;
    int unsigned       n;
    int unsigned       flat;
    logic [TexelW-1:0] col_keep;
    logic [TexelW-1:0] row_keep;
    logic [TexelW-1:0] above_raw;
    logic [TexelW-1:0] left_nb;
    logic [TexelW-1:0] above_nb;
    logic [TexelW-1:0] corner_nb;
    bit                row_end;
    bit                glyph_end;
    pixel_t            px;
    w         = active_dim(glyph_w, MaxW);
    h         = active_dim(glyph_h, MaxH);
    col_keep  = {4{4'hf >> shift_x}};
    row_keep  = 16'hffff >> (4 * shift_y);
    above_raw = line_buf[col_cnt[ColBits-1:0]];
    left_nb   = (col_cnt > 0) ? left_texel : '0;
    above_nb  = (row_cnt > 0) ? above_raw : '0;
    corner_nb = (col_cnt > 0 && row_cnt > 0) ? corner_texel : '0;
    n = $countones(cur & col_keep & row_keep) + $countones(left_nb & ~col_keep & row_keep)
      + $countones(above_nb & col_keep & ~row_keep)
      + $countones(corner_nb & ~col_keep & ~row_keep);
    px.gray   = (n >= 16) ? GrayFull : GrayW'(n * 16);
    flat      = (32'(dest_top) + row_cnt) * 32'(dest_stride) + 32'(dest_left) + col_cnt;
    px.index  = flat[IndexW-1:0];
    row_end   = (col_cnt + 1 >= w);
    glyph_end = row_end && (row_cnt + 1 >= h);
    px.last   = glyph_end;
    corner_texel      = above_raw;
    line_buf[col_cnt[ColBits-1:0]] = cur;
    left_texel        = cur;
    if (row_end) begin
      col_cnt = 0;
      row_cnt = glyph_end ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return px;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned got,
                               input int unsigned want_v);
    if (mismatch_count < 30) begin
      $display("%0t ns: mismatch on %s, got %0h want %0h", $time, field, got, want_v);
    end
    mismatch_count++;
  endtask

  task automatic set_reg(input cfg_reg_e sel, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= sel;
    cfg_wdata_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (sel)
      CfgGlyphWidth:  glyph_w     = value[DimW-1:0];
      CfgGlyphHeight: glyph_h     = value[DimW-1:0];
      CfgShiftX:      shift_x     = value[ShiftW-1:0];
      CfgShiftY:      shift_y     = value[ShiftW-1:0];
      CfgDestLeft:    dest_left   = value[OffsW-1:0];
      CfgDestTop:     dest_top    = value[OffsW-1:0];
      CfgDestStride:  dest_stride = value[StrideW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_texel(input logic [TexelW-1:0] t, input bit typed, input pixel_t typed_px);
    int unsigned gap;
    pixel_t      px;
    gap = draw_wait(feed_pace);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    texel_i    <= t;
    do @(posedge clk_i); while (!in_ready_o);
    px = render_texel(t);
    pixel_q.push_back(typed ? typed_px : px);
    texels_sent++;
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // output side: random stalls, one long hold-off on request, word checks
  initial begin : sink
    int unsigned stall;
    pixel_t      want;
    out_ready_i <= 1'b0;
    sink_pace = 1;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end else begin
        stall = draw_wait(sink_pace);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pixel_q.size() == 0) begin
        flag_mismatch("unexpected word", 32'(dest_index_o), 0);
      end else begin
        want = pixel_q.pop_front();
        if (gray_o !== want.gray) begin
          flag_mismatch("gray", 32'(gray_o), 32'(want.gray));
        end
        if (dest_index_o !== want.index) begin
          flag_mismatch("dest_index", 32'(dest_index_o), 32'(want.index));
        end
        if (last_pixel_o !== want.last) begin
          flag_mismatch("last_pixel", 32'(last_pixel_o), 32'(want.last));
        end
      end
      if ($urandom_range(0, 49) == 0) sink_pace = $urandom_range(0, 2);
    end
  end

  initial begin : source
    int unsigned pick;
    int unsigned span_w;
    int unsigned span_h;
    int unsigned span;
    int unsigned burst;
    int unsigned stride_v;
    bit          fresh;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgGlyphWidth;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    texel_i     <= '0;
    hold_req       = 1'b0;
    texels_sent    = 0;
    mismatch_count = 0;
    feed_pace      = 1;
    clear_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == StepWrite) begin
        settle_block();
        set_reg(plan[i].sel, plan[i].value);
      end else begin
        push_texel(plan[i].value, plan[i].checked, plan[i].want);
      end
    end

    // back-pressure: receiver holds off while texels keep coming
    settle_block();
    feed_pace = 0;
    hold_req  = 1'b1;
    repeat (40) push_texel(draw_mask(), 1'b0, '0);

    while (texels_sent < TotalItems) begin
      settle_block();
      fresh = (col_cnt == 0 && row_cnt == 0);
      if (fresh && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          span_w = $urandom_range(257, 511);
          span_h = $urandom_range(0, 1);
        end else if (pick == 1) begin
          span_w = $urandom_range(0, 1);
          span_h = $urandom_range(256, 511);
        end else if (pick < 5) begin
          span_w = 0;
          span_h = $urandom_range(1, 8);
        end else if (pick < 7) begin
          span_w = $urandom_range(1, 8);
          span_h = 0;
        end else begin
          span_w = $urandom_range(1, 8);
          span_h = $urandom_range(1, 8);
        end
        set_reg(CfgGlyphWidth, 16'(span_w));
        set_reg(CfgGlyphHeight, 16'(span_h));
      end else if (!fresh && $urandom_range(0, 1) == 0) begin
        // mid-glyph: only narrow, so no unwritten line entry is read
        if ($urandom_range(0, 1) == 0) begin
          set_reg(CfgGlyphWidth, 16'($urandom_range(0, active_dim(glyph_w, MaxW))));
        end else begin
          set_reg(CfgGlyphHeight, 16'($urandom_range(0, row_cnt + 1)));
        end
      end
      if ($urandom_range(0, 1) == 0) set_reg(CfgShiftX, 16'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) set_reg(CfgShiftY, 16'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) == 0) set_reg(CfgDestLeft, pick_offset());
      if ($urandom_range(0, 2) == 0) set_reg(CfgDestTop, pick_offset());
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       stride_v = 0;
          1:       stride_v = 1;
          2:       stride_v = 4096;
          3:       stride_v = 8191;
          default: stride_v = $urandom_range(2, 4095);
        endcase
        set_reg(CfgDestStride, 16'(stride_v));
      end
      if (fresh && $urandom_range(0, 3) != 0) begin
        span  = active_dim(glyph_w, MaxW) * active_dim(glyph_h, MaxH);
        burst = (span > 64) ? span : span * $urandom_range(1, 3);
      end else begin
        burst = $urandom_range(1, 40);
      end
      feed_pace = $urandom_range(0, 2);
      repeat (burst) push_texel(draw_mask(), 1'b0, '0);
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
